### rtl/bdm_pkg.sv
// bdm_pkg: shared types and constants for the button debounce and mode event block
// used by bdm_lane, bdm_merge and button_debounce_mode_events; no dependencies
package bdm_pkg;

  // button count the block is built for, and the lanes actually instantiated
  localparam int NumButtons = 16;
  localparam int PinW       = 16;
  localparam int NumLanes   = (NumButtons < PinW) ? NumButtons : PinW;

  // fixed field and register widths
  localparam int IdxW   = 4;
  localparam int CntW   = 8;
  localparam int CountW = 5;
  localparam int ModesW = 32;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;

  // reset values of the configuration registers
  localparam logic [CntW-1:0]   DebounceReset = CntW'(20);
  localparam logic [ModesW-1:0] ModesReset    = '0;
  localparam logic [CountW-1:0] CountReset    = '0;
  localparam logic [CntW-1:0]   CntMax        = '1;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE_MS  = 2'd0,
    CFG_BUTTON_MODES = 2'd1,
    CFG_BUTTON_COUNT = 2'd2
  } cfg_reg_e;

  // per-button event modes
  typedef enum logic [1:0] {
    MODE_BANG   = 2'd0,
    MODE_TOGGLE = 2'd1,
    MODE_SWITCH = 2'd2,
    MODE_SILENT = 2'd3
  } mode_e;

  // what one lane found on a tick
  typedef struct packed {
    logic send;
    logic value;
  } lane_result_t;

  // one result transaction
  typedef struct packed {
    logic [IdxW-1:0] button_index;
    logic            event_value;
    logic            last_of_tick;
  } event_t;

endpackage

### rtl/bdm_lane.sv
// bdm_lane: debounce counter and mode logic for a single button
// depends on bdm_pkg
module bdm_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          tick_i,
  input  logic                          active_i,
  input  logic                          pin_i,
  input  bdm_pkg::mode_e                mode_i,
  input  logic [bdm_pkg::CntW-1:0]      debounce_ms_i,
  output bdm_pkg::lane_result_t         result_o
);

  logic                     last_raw_q, last_raw_d;
  logic [bdm_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                     deb_q, deb_d;
  logic                     seen_q, seen_d;
  logic                     tog_q, tog_d;
  logic                     raw;
  logic                     send;
  logic                     value;

  // debounce: restart on raw change, else saturating count
  always_comb begin
    raw        = ~pin_i;
    last_raw_d = raw;
    if (raw != last_raw_q) begin
      cnt_d = '0;
    end else if (cnt_q != bdm_pkg::CntMax) begin
      cnt_d = cnt_q + 1'b1;
    end else begin
      cnt_d = cnt_q;
    end
    deb_d = (cnt_d > debounce_ms_i) ? raw : deb_q;
  end

  // mode logic on the new debounced level
  always_comb begin
    seen_d = seen_q;
    tog_d  = tog_q;
    send   = 1'b0;
    value  = 1'b0;
    case (mode_i)
      bdm_pkg::MODE_BANG, bdm_pkg::MODE_TOGGLE: begin
        if (deb_d && !seen_q) begin
          seen_d = 1'b1;
          send   = 1'b1;
          if (mode_i == bdm_pkg::MODE_TOGGLE) begin
            tog_d = ~tog_q;
            value = ~tog_q;
          end else begin
            value = 1'b1;
          end
        end else if (!deb_d) begin
          seen_d = 1'b0;
        end
      end
      bdm_pkg::MODE_SWITCH: begin
        if (deb_d != seen_q) begin
          seen_d = deb_d;
          send   = 1'b1;
          value  = deb_d;
        end
      end
      default: begin
      end
    endcase
  end

  assign result_o.send  = send && active_i;
  assign result_o.value = value;

  // state advances only on an accepted tick for an active button
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q <= 1'b0;
      cnt_q      <= '0;
      deb_q      <= 1'b0;
      seen_q     <= 1'b0;
      tog_q      <= 1'b0;
    end else if (tick_i && active_i) begin
      last_raw_q <= last_raw_d;
      cnt_q      <= cnt_d;
      deb_q      <= deb_d;
      seen_q     <= seen_d;
      tog_q      <= tog_d;
    end
  end

endmodule

### rtl/bdm_merge.sv
// bdm_merge: collects the lane results of a tick and sends them out in index order
// depends on bdm_pkg
module bdm_merge (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                tick_i,
  input  bdm_pkg::lane_result_t [bdm_pkg::NumLanes-1:0] lanes_i,
  output logic                                busy_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output bdm_pkg::event_t                     event_o
);

  logic [bdm_pkg::NumLanes-1:0] pending_q, pending_d;
  logic [bdm_pkg::NumLanes-1:0] vals_q, vals_d;
  logic [bdm_pkg::NumLanes-1:0] rest;
  logic [bdm_pkg::IdxW-1:0]     pick;
  logic                         pop;
  logic                         out_valid_q, out_valid_d;
  bdm_pkg::event_t              event_q, event_d;

  // lowest pending button
  always_comb begin
    pick = '0;
    for (int i = bdm_pkg::NumLanes - 1; i >= 0; i--) begin
      if (pending_q[i]) begin
        pick = bdm_pkg::IdxW'(i);
      end
    end
    rest       = pending_q;
    rest[pick] = 1'b0;
  end

  assign pop = (pending_q != '0) && (!out_valid_q || !out_stall_i);

  // pending mask: loaded on a tick, drained one event per pop
  always_comb begin
    pending_d = pending_q;
    vals_d    = vals_q;
    if (tick_i) begin
      for (int i = 0; i < bdm_pkg::NumLanes; i++) begin
        pending_d[i] = lanes_i[i].send;
        vals_d[i]    = lanes_i[i].value;
      end
    end else if (pop) begin
      pending_d = rest;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    event_d     = event_q;
    if (pop) begin
      out_valid_d          = 1'b1;
      event_d.button_index = pick;
      event_d.event_value  = vals_q[pick];
      event_d.last_of_tick = (rest == '0);
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pending_q   <= pending_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vals_q  <= vals_d;
    event_q <= event_d;
  end

  assign busy_o      = (pending_q != '0);
  assign out_valid_o = out_valid_q;
  assign event_o     = event_q;

  // the chosen button is always one that is pending
  a_pick_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q != '0) |-> pending_q[pick])
    else $error("picked button is not pending");

  // a popped button leaves the pending mask
  a_pop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> !pending_q[$past(pick)])
    else $error("popped button still pending");

  // last flag marks the pop that empties the mask
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (event_q.last_of_tick == ($past(rest) == '0)))
    else $error("last_of_tick does not match drained mask");

  // a new tick is never loaded over pending events
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_i |-> (pending_q == '0))
    else $error("tick loaded while events pending");

endmodule

### rtl/button_debounce_mode_events.sv
// Button debounce with per-button event modes. Each accepted transaction on the input
// channel is one millisecond tick of active-low pin levels. All buttons are debounced
// and evaluated together by parallel lanes; the events of a tick then leave the merge
// stage one event per cycle while the output does not stall, lowest button index first,
// with last_of_tick on the final one. The next tick is accepted in the cycle after every
// event of the previous one has moved into the output register; the input is stalled
// until then. A tick that causes no event produces no result transaction. Configuration
// writes are always accepted (cfg_ready_o is tied high); index 3 is ignored.
// depends on bdm_pkg, bdm_lane, bdm_merge
module button_debounce_mode_events (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tick input
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [bdm_pkg::PinW-1:0]          pin_levels_i,
  // event output
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [bdm_pkg::IdxW-1:0]          button_index_o,
  output logic                              event_value_o,
  output logic                              last_of_tick_o,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bdm_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [bdm_pkg::CfgDataW-1:0]      cfg_data_i
);

  logic [bdm_pkg::CntW-1:0]   debounce_ms_q;
  logic [bdm_pkg::ModesW-1:0] button_modes_q;
  logic [bdm_pkg::CountW-1:0] button_count_q;
  logic                       tick;
  logic                       busy;
  bdm_pkg::lane_result_t [bdm_pkg::NumLanes-1:0] lanes;
  bdm_pkg::event_t            event_out;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy;
  assign tick        = in_valid_i && !busy;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ms_q  <= bdm_pkg::DebounceReset;
      button_modes_q <= bdm_pkg::ModesReset;
      button_count_q <= bdm_pkg::CountReset;
    end else if (cfg_valid_i) begin
      case (bdm_pkg::cfg_reg_e'(cfg_index_i))
        bdm_pkg::CFG_DEBOUNCE_MS:  debounce_ms_q  <= cfg_data_i[bdm_pkg::CntW-1:0];
        bdm_pkg::CFG_BUTTON_MODES: button_modes_q <= cfg_data_i[bdm_pkg::ModesW-1:0];
        bdm_pkg::CFG_BUTTON_COUNT: button_count_q <= cfg_data_i[bdm_pkg::CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  // one lane per button
  for (genvar g = 0; g < bdm_pkg::NumLanes; g++) begin : g_lane
    bdm_lane u_lane (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .tick_i        (tick),
      .active_i      (bdm_pkg::CountW'(g) < button_count_q),
      .pin_i         (pin_levels_i[g]),
      .mode_i        (bdm_pkg::mode_e'(button_modes_q[2*g +: 2])),
      .debounce_ms_i (debounce_ms_q),
      .result_o      (lanes[g])
    );
  end

  // event ordering and output register
  bdm_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (tick),
    .lanes_i     (lanes),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .event_o     (event_out)
  );

  assign button_index_o = event_out.button_index;
  assign event_value_o  = event_out.event_value;
  assign last_of_tick_o = event_out.last_of_tick;

endmodule

### tb/button_debounce_mode_events_checker.sv
// button_debounce_mode_events_checker: watches the tick, event and register channels,
// keeps its own copy of the debounce and mode state and compares every event in order
// depends on bdm_pkg
`timescale 1ns / 1ps

module button_debounce_mode_events_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tick channel
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [bdm_pkg::PinW-1:0]      pin_levels_i,
  // event channel
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [bdm_pkg::IdxW-1:0]      button_index_i,
  input  logic                          event_value_i,
  input  logic                          last_of_tick_i,
  // register channel
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [bdm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bdm_pkg::CfgDataW-1:0]  cfg_data_i,
  // status for the testbench top
  output int                            fail_count_o,
  output int                            pending_o
);

  localparam int Lanes = bdm_pkg::PinW;

  // shadow registers
  logic [bdm_pkg::CntW-1:0]   debounce_ms_q;
  logic [bdm_pkg::ModesW-1:0] modes_q;
  logic [bdm_pkg::CountW-1:0] count_q;

  // shadow per-button state
  logic                     last_raw   [Lanes];
  logic [bdm_pkg::CntW-1:0] stable_cnt [Lanes];
  logic                     debounced  [Lanes];
  logic                     seen_level [Lanes];
  logic                     toggle_bit [Lanes];

  // events predicted but not yet seen on the output
  bdm_pkg::event_t expected_events[$];
  bdm_pkg::event_t want;

  // one tick: debounce the active buttons, then run each mode in index order
  function automatic void predict_events(input logic [bdm_pkg::PinW-1:0] pins);
    int              active;
    int              last_btn;
    logic            pressed;
    logic            fire     [Lanes];
    logic            fire_val [Lanes];
    bdm_pkg::mode_e  mode;
    bdm_pkg::event_t ev;
    active   = (int'(count_q) > bdm_pkg::NumLanes) ? bdm_pkg::NumLanes : int'(count_q);
    last_btn = -1;
    for (int i = 0; i < active; i++) begin
      pressed = ~pins[i];
      if (pressed != last_raw[i]) begin
        last_raw[i]   = pressed;
        stable_cnt[i] = '0;
      end else if (stable_cnt[i] != bdm_pkg::CntMax) begin
        stable_cnt[i] = stable_cnt[i] + 1'b1;
      end
      if (stable_cnt[i] > debounce_ms_q) debounced[i] = pressed;
    end
    for (int i = 0; i < active; i++) begin
      fire[i]     = 1'b0;
      fire_val[i] = 1'b0;
      mode        = bdm_pkg::mode_e'(modes_q[2*i +: 2]);
      case (mode)
        bdm_pkg::MODE_BANG, bdm_pkg::MODE_TOGGLE: begin
          if (debounced[i] && !seen_level[i]) begin
            seen_level[i] = 1'b1;
            fire[i]       = 1'b1;
            if (mode == bdm_pkg::MODE_TOGGLE) begin
              toggle_bit[i] = ~toggle_bit[i];
              fire_val[i]   = toggle_bit[i];
            end else begin
              fire_val[i] = 1'b1;
            end
          end else if (!debounced[i]) begin
            seen_level[i] = 1'b0;
          end
        end
        bdm_pkg::MODE_SWITCH: begin
          if (debounced[i] != seen_level[i]) begin
            seen_level[i] = debounced[i];
            fire[i]       = 1'b1;
            fire_val[i]   = debounced[i];
          end
        end
        default: ;
      endcase
      if (fire[i]) last_btn = i;
    end
    for (int i = 0; i < active; i++) begin
      if (fire[i]) begin
        ev.button_index = bdm_pkg::IdxW'(i);
        ev.event_value  = fire_val[i];
        ev.last_of_tick = (i == last_btn);
        expected_events.push_back(ev);
      end
    end
  endfunction

  // print one line per mismatch and count it
  task automatic report_mismatch(input string what, input int wanted, input int got);
    $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, wanted, got);
    fail_count_o++;
  endtask

  // watch all three channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ms_q = bdm_pkg::DebounceReset;
      modes_q       = bdm_pkg::ModesReset;
      count_q       = bdm_pkg::CountReset;
      for (int i = 0; i < Lanes; i++) begin
        last_raw[i]   = 1'b0;
        stable_cnt[i] = '0;
        debounced[i]  = 1'b0;
        seen_level[i] = 1'b0;
        toggle_bit[i] = 1'b0;
      end
      expected_events.delete();
      fail_count_o = 0;
      pending_o   <= 0;
    end else begin
      // event transaction against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (expected_events.size() == 0) begin
          report_mismatch("unexpected event, button", -1, int'(button_index_i));
        end else begin
          want = expected_events.pop_front();
          if (button_index_i != want.button_index)
            report_mismatch("button_index", int'(want.button_index), int'(button_index_i));
          if (event_value_i != want.event_value)
            report_mismatch("event_value", int'(want.event_value), int'(event_value_i));
          if (last_of_tick_i != want.last_of_tick)
            report_mismatch("last_of_tick", int'(want.last_of_tick), int'(last_of_tick_i));
        end
      end
      // register write, unknown index ignored
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          bdm_pkg::CFG_DEBOUNCE_MS:  debounce_ms_q = cfg_data_i[bdm_pkg::CntW-1:0];
          bdm_pkg::CFG_BUTTON_MODES: modes_q       = cfg_data_i[bdm_pkg::ModesW-1:0];
          bdm_pkg::CFG_BUTTON_COUNT: count_q       = cfg_data_i[bdm_pkg::CountW-1:0];
          default: ;
        endcase
      end
      // tick transaction
      if (in_valid_i && !in_stall_i) predict_events(pin_levels_i);
      pending_o <= expected_events.size();
    end
  end

endmodule

### tb/button_debounce_mode_events_tb.sv
// button_debounce_mode_events_tb: drives ticks and register writes into the block with
// random idling on both sides and gives the verdict from the checker's count
// depends on bdm_pkg, button_debounce_mode_events, button_debounce_mode_events_checker
`timescale 1ns / 1ps

module button_debounce_mode_events_tb;

  localparam logic [bdm_pkg::CfgIdxW-1:0] CfgIgnored = 2'd3;
  localparam int DrainCycles   = 24;
  localparam int HoldCycles    = 300;
  localparam int WatchdogLimit = 4000;
  localparam int PhaseTicks    = 40;
  localparam int NumPhases     = 8;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // tick channel
  logic                        tick_valid = 1'b0;
  logic                        tick_stall;
  logic [bdm_pkg::PinW-1:0]    pin_levels = '1;
  // event channel
  logic                        event_valid;
  logic                        event_stall = 1'b0;
  logic [bdm_pkg::IdxW-1:0]    button_index;
  logic                        event_value;
  logic                        last_of_tick;
  // register channel
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [bdm_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [bdm_pkg::CfgDataW-1:0] cfg_data = '0;

  int fail_count;
  int pending_count;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req      = 0;
  int hold_ack      = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int debounce_now  = 20;
  int run_left      = 0;
  logic [bdm_pkg::PinW-1:0] held_pins = '1;

  // pressed, released and mixed patterns for the all-modes directed run
  logic [bdm_pkg::PinW-1:0] mixed_seq [11] = '{
    16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000,
    16'h0000, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555
  };

  always #5 clk_i = ~clk_i;

  button_debounce_mode_events i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (tick_valid),
    .in_stall_o     (tick_stall),
    .pin_levels_i   (pin_levels),
    .out_valid_o    (event_valid),
    .out_stall_i    (event_stall),
    .button_index_o (button_index),
    .event_value_o  (event_value),
    .last_of_tick_o (last_of_tick),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  button_debounce_mode_events_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (tick_valid),
    .in_stall_i     (tick_stall),
    .pin_levels_i   (pin_levels),
    .out_valid_i    (event_valid),
    .out_stall_i    (event_stall),
    .button_index_i (button_index),
    .event_value_i  (event_value),
    .last_of_tick_i (last_of_tick),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending_count)
  );

  // event receiver: random stall, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      event_stall <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      event_stall <= 1'b1;
      hold_left   <= HoldCycles;
      hold_ack    <= hold_req;
    end else begin
      event_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((tick_valid && !tick_stall) || (event_valid && !event_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one tick, with random idle cycles in front
  task send_tick(input logic [bdm_pkg::PinW-1:0] pins);
    while ($urandom_range(99) < send_idle_pct) begin
      tick_valid <= 1'b0;
      @(posedge clk_i);
    end
    tick_valid <= 1'b1;
    pin_levels <= pins;
    @(posedge clk_i);
    while (tick_stall) @(posedge clk_i);
  endtask

  // stop offering and wait until every predicted event is out and the block is quiet
  task settle();
    tick_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // one register write; valid is left high for a following write
  task write_reg(input logic [bdm_pkg::CfgIdxW-1:0] idx,
                 input logic [bdm_pkg::CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
  endtask

  // all three registers, unused upper data bits random
  task configure(input logic [bdm_pkg::CntW-1:0] deb, input logic [bdm_pkg::ModesW-1:0] modes,
                 input logic [bdm_pkg::CountW-1:0] cnt);
    write_reg(bdm_pkg::CFG_DEBOUNCE_MS, ($urandom() & 32'hFFFF_FF00) | 32'(deb));
    write_reg(bdm_pkg::CFG_BUTTON_MODES, modes);
    write_reg(bdm_pkg::CFG_BUTTON_COUNT, ($urandom() & 32'hFFFF_FFE0) | 32'(cnt));
    cfg_valid    <= 1'b0;
    debounce_now = deb;
  endtask

  // mostly held patterns long enough to debounce, with bounce noise in between
  function logic [bdm_pkg::PinW-1:0] next_pins();
    if ($urandom_range(99) < 15) return bdm_pkg::PinW'($urandom());
    if (run_left == 0) begin
      case ($urandom_range(2))
        0:       held_pins ^= bdm_pkg::PinW'(1 << $urandom_range(15));
        1:       held_pins ^= bdm_pkg::PinW'($urandom() & $urandom());
        default: held_pins = bdm_pkg::PinW'($urandom());
      endcase
      run_left = ((debounce_now < 6) ? debounce_now + 1 : 3) + $urandom_range(3);
    end
    run_left--;
    return held_pins;
  endfunction

  // stimulus and verdict
  initial begin
    logic [bdm_pkg::CntW-1:0]   deb;
    logic [bdm_pkg::CountW-1:0] cnt;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 8;
    recv_idle_pct = 48;

    // reset settings: no active buttons, and a write to the unused index
    write_reg(CfgIgnored, 32'hFFFF_FFFF);
    cfg_valid <= 1'b0;
    send_tick(16'h0000);
    send_tick(16'hFFFF);
    settle();

    // all four modes side by side, zero debounce, change tick never follows
    configure(8'd0, 32'hE4E4_E4E4, 5'd16);
    foreach (mixed_seq[k]) send_tick(mixed_seq[k]);
    settle();

    // debounce at maximum with an oversized count: nothing may follow
    configure(8'd255, 32'hAAAA_AAAA, 5'd31);
    send_tick(16'hFFFF);
    repeat (3) send_tick(16'h0000);
    settle();

    // three toggle buttons, the rest must hold their state
    configure(8'd2, 32'h5555_5555, 5'd3);
    repeat (4) send_tick(16'h0000);
    repeat (4) send_tick(16'hFFFF);
    settle();

    // random phases: sender-light, receiver-light, then no idling
    for (int phase = 0; phase < NumPhases; phase++) begin
      if (phase < 3) begin
        send_idle_pct = 8;
        recv_idle_pct = 48;
      end else if (phase < 6) begin
        send_idle_pct = 48;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case ($urandom_range(15))
        0:       deb = 8'd254;
        1:       deb = 8'd255;
        default: deb = bdm_pkg::CntW'($urandom_range(4));
      endcase
      cnt = ($urandom_range(3) == 0) ? bdm_pkg::CountW'($urandom_range(31)) : 5'd16;
      // busy settings for the phase with the long receiver hold-off
      if (phase == 1) begin
        deb = 8'd0;
        cnt = 5'd16;
      end
      configure(deb, $urandom(), cnt);
      held_pins = bdm_pkg::PinW'($urandom());
      run_left  = 0;
      for (int t = 0; t < PhaseTicks; t++) begin
        if (phase == 1 && t == 10) hold_req++;
        if (phase == 4 && t == 20) settle();
        send_tick(next_pins());
      end
      settle();
    end

    if (fail_count == 0 && pending_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
